/* rtl/tgl_pkg.sv */
// Shared types and constants for the tile grid line-of-sight block.
`timescale 1ns / 1ps
package tgl_pkg;

    localparam int POS_W   = 22;
    localparam int DIV_W   = 30;
    localparam int SLOPE_W = DIV_W + 1;
    localparam int PART_W  = 9;
    localparam int PROD_W  = SLOPE_W + PART_W + 1;
    localparam int FRAC_W  = 40;
    localparam int CELL_W  = 10;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] DOOR_OPEN   = 2'd0;
    localparam logic [1:0] DOOR_CLOSED = 2'd1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLR   = 9'b000000010,
        S_SETUP = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_INIT  = 9'b000100000,
        S_RD    = 9'b001000000,
        S_CHK   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

endpackage

/* rtl/tile_grid_line_of_sight.sv */
// Tile map store with a line-of-sight query walked cell by cell.
// A write request is stored as it is accepted. A query walks each axis through setup, a divide,
// a multiply and an init state, then a read and a check per crossed border (one map read each);
// an axis with no crossing ends after setup. The result is registered as the walk leaves the
// done state, with the block ready again; a blocking cell ends the walk early, and an unread
// result holds the finish. Reset (synchronous, active low) starts a clear pass over all
// 2^(2*MAP_SIDE_LOG2) cells, one cell per cycle, during which no request is accepted.
`timescale 1ns / 1ps
module tile_grid_line_of_sight #(
    parameter int MAP_SIDE_LOG2      = 6,
    parameter int TILE_FRACTION_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic [5:0]                i_cell_x,
    input  logic [5:0]                i_cell_y,
    input  logic                      i_wall_flag,
    input  logic                      i_door_flag,
    input  logic [1:0]                i_door_state,
    input  logic [5:0]                i_door_progress,
    input  logic [tgl_pkg::POS_W-1:0] i_start_x,
    input  logic [tgl_pkg::POS_W-1:0] i_start_y,
    input  logic [tgl_pkg::POS_W-1:0] i_end_x,
    input  logic [tgl_pkg::POS_W-1:0] i_end_y,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_line_clear
);
    import tgl_pkg::*;

    localparam int L         = MAP_SIDE_LOG2;
    localparam int ADDR_W    = 2 * L;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int SUB_SHIFT = TILE_FRACTION_BITS - 8;
    localparam int TILE_W    = POS_W - TILE_FRACTION_BITS;
    localparam int DCNT_W    = $clog2(DIV_W);

    logic [CELL_W-1:0] mem [MEM_DEPTH];

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr;
    logic [POS_W-1:0] r_x1, r_y1, r_x2, r_y2, r_b1;
    logic r_col, r_up, r_neg, r_res, r_ov, r_clear;
    logic [TILE_W-1:0] r_n, r_cnt;
    logic [PART_W-1:0] r_part;
    logic [POS_W-1:0] r_delta;
    logic [POS_W:0] r_rem;
    logic [DIV_W-1:0] r_dq;
    logic [DCNT_W-1:0] r_dcnt;
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [FRAC_W-1:0] r_frac;
    logic [L-1:0] r_t;
    logic [CELL_W-1:0] r_rdata;

    logic w_acc, w_out_free;
    logic [POS_W-1:0] w_a1, w_a2, w_b1, w_b2, w_delta;
    logic [TILE_W-1:0] w_at1, w_at2;
    logic w_up;
    logic signed [POS_W:0] w_db;
    logic [POS_W:0] w_mag;
    logic [POS_W:0] w_rem_sh, w_rem_nx;
    logic w_ge;
    logic signed [SLOPE_W-1:0] w_slope;
    logic signed [PROD_W-1:0] w_prod_sh;
    logic [L-1:0] w_t_nx, w_o;
    logic [ADDR_W-1:0] w_raddr, w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic w_we;
    logic [8:0] w_hs9;
    logic [7:0] w_ic8;
    logic [5:0] w_thr;
    logic w_block;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ov;
    assign o_line_clear = r_clear;
    assign w_acc        = i_valid && o_ready;
    assign w_out_free   = !r_ov || i_ready;

    // walk axis selection: column walk uses x as the walked axis
    assign w_a1  = r_col ? r_x1 : r_y1;
    assign w_a2  = r_col ? r_x2 : r_y2;
    assign w_b1  = r_col ? r_y1 : r_x1;
    assign w_b2  = r_col ? r_y2 : r_x2;
    assign w_at1 = w_a1[8 +: TILE_W];
    assign w_at2 = w_a2[8 +: TILE_W];
    assign w_up  = w_at2 > w_at1;
    assign w_delta = (w_a2 > w_a1) ? (w_a2 - w_a1) : (w_a1 - w_a2);
    assign w_db  = $signed({1'b0, w_b2}) - $signed({1'b0, w_b1});
    assign w_mag = w_db[POS_W] ? (POS_W+1)'(-w_db) : w_db;

    // restoring divide step
    assign w_rem_sh = {r_rem[POS_W-1:0], r_dq[DIV_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_delta};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_delta}) : w_rem_sh;
    assign w_slope  = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    assign w_prod_sh = r_prod >>> 8;

    // walk step address
    assign w_t_nx  = r_up ? (r_t + L'(1)) : (r_t - L'(1));
    assign w_o     = r_frac[8 +: L];
    assign w_raddr = r_col ? {w_t_nx, w_o} : {w_o, w_t_nx};

    // door intercept test
    assign w_hs9  = r_slope[8:0] + {8'd0, r_slope[SLOPE_W-1]};
    assign w_ic8  = r_frac[7:0] - w_hs9[8:1];
    assign w_thr  = r_col ? ~r_rdata[9:4] : r_rdata[9:4];
    always_comb begin
        if (r_rdata[0]) begin
            w_block = 1'b1;
        end else if (!r_rdata[1]) begin
            w_block = 1'b0;
        end else begin
            case (r_rdata[3:2])
                DOOR_OPEN:   w_block = 1'b0;
                DOOR_CLOSED: w_block = 1'b1;
                default:     w_block = w_ic8[7:2] < w_thr;
            endcase
        end
    end

    assign w_we    = (r_state == S_CLR) || (w_acc && (i_op == OP_WRITE));
    assign w_waddr = (r_state == S_CLR) ? r_clr : {L'(i_cell_x), L'(i_cell_y)};
    assign w_wdata = (r_state == S_CLR) ? '0 :
                     {i_door_progress, i_door_state, i_door_flag, i_wall_flag};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && (i_op == OP_QUERY)) n_state = S_SETUP;
            end
            S_CLR: begin
                if (&r_clr) n_state = S_IDLE;
            end
            S_SETUP: begin
                if ((w_at1 == w_at2) || (w_delta == '0)) begin
                    n_state = r_col ? S_SETUP : S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_dcnt == DCNT_W'(DIV_W - 1)) n_state = S_MUL;
            end
            S_MUL:  n_state = S_INIT;
            S_INIT: n_state = S_RD;
            S_RD:   n_state = S_CHK;
            S_CHK: begin
                if (w_block) begin
                    n_state = S_DONE;
                end else if (r_cnt == r_n) begin
                    n_state = r_col ? S_SETUP : S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + ADDR_W'(1);
            if (r_state == S_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x1  <= i_start_x >> SUB_SHIFT;
                r_y1  <= i_start_y >> SUB_SHIFT;
                r_x2  <= i_end_x >> SUB_SHIFT;
                r_y2  <= i_end_y >> SUB_SHIFT;
                r_col <= 1'b1;
                r_res <= 1'b1;
            end
            S_SETUP: begin
                r_up    <= w_up;
                r_n     <= w_up ? (w_at2 - w_at1) : (w_at1 - w_at2);
                r_part  <= w_up ? (PART_W'(256) - {1'b0, w_a1[7:0]}) : {1'b0, w_a1[7:0]};
                r_delta <= w_delta;
                r_neg   <= w_db[POS_W];
                r_dq    <= {w_mag[POS_W-1:0], 8'd0};
                r_rem   <= '0;
                r_dcnt  <= '0;
                r_cnt   <= '0;
                r_t     <= L'(w_at1);
                r_b1    <= w_b1;
                if ((w_at1 == w_at2) || (w_delta == '0)) r_col <= 1'b0;
            end
            S_DIV: begin
                r_rem  <= w_rem_nx;
                r_dq   <= {r_dq[DIV_W-2:0], w_ge};
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            S_MUL: begin
                r_slope <= w_slope;
                r_prod  <= PROD_W'(w_slope) * PROD_W'($signed({1'b0, r_part}));
            end
            S_INIT: begin
                r_frac <= $signed(FRAC_W'({1'b0, r_b1})) + FRAC_W'(w_prod_sh);
            end
            S_RD: begin
                r_t    <= w_t_nx;
                r_frac <= r_frac + FRAC_W'(r_slope);
                r_cnt  <= r_cnt + TILE_W'(1);
            end
            S_CHK: begin
                if (w_block) begin
                    r_res <= 1'b0;
                end else if (r_cnt == r_n) begin
                    r_col <= 1'b0;
                end
            end
            S_DONE: begin
                if (w_out_free) r_clear <= r_res;
            end
            default: ;
        endcase
    end

endmodule
